// ----- rtl/assert_macros.svh -----
// Assertion helpers included by the top-level RTL file.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`define ASSERT_NEVER(label, cond)
`endif
`endif

// ----- rtl/gdc_pkg.sv -----
// Shared types and constants of the graph colorer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gdc_pkg;
  localparam int MAX_VERTICES_DEF = 32;
  localparam int VIDX_W = 6;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DEG,
    ST_RANK,
    ST_CLASS_RD,
    ST_CLASS_CHK,
    ST_EMIT
  } gdc_state_t;

  typedef struct packed {
    logic              deg_we;
    logic              rank_clr;
    logic              rank_en;
    logic              color_clr;
    logic              color_we;
    logic [VIDX_W-1:0] sel;
    logic [VIDX_W:0]   deg_val;
    logic [VIDX_W:0]   color_val;
  } lane_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/gdc_in_if.sv -----
// Stream channel interfaces for row beats and result beats.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface gdc_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  row_index;
  logic [31:0] adjacency_row;
  logic        last_row;
  modport source (output valid, row_index, adjacency_row, last_row, input ready);
  modport sink (input valid, row_index, adjacency_row, last_row, output ready);
endinterface

interface gdc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] vertex;
  logic [5:0] color;
  logic [5:0] color_count;
  logic       last_result;
  modport source (output valid, vertex, color, color_count, last_result, input ready);
  modport sink (input valid, vertex, color, color_count, last_result, output ready);
endinterface
`default_nettype wire

// ----- rtl/gdc_lane.sv -----
// One vertex lane: degree, rank among active vertices, and assigned color.
// Depends on gdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gdc_lane #(
  parameter int MAX_VERTICES = gdc_pkg::MAX_VERTICES_DEF,
  parameter int LANE = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gdc_pkg::lane_ctl_t ctl,
  output logic [$clog2(MAX_VERTICES+1)-1:0] deg,
  output logic [$clog2(MAX_VERTICES)-1:0]   rank,
  output logic [$clog2(MAX_VERTICES+1)-1:0] color
);
  import gdc_pkg::*;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [CW-1:0] deg_r, color_r;
  logic [VW-1:0] rank_r;
  logic          mine, beats;

  assign mine  = (ctl.sel == VIDX_W'(LANE));
  // broadcast vertex outranks this one: higher degree, or equal and lower index
  assign beats = (CW'(ctl.deg_val) > deg_r) ||
                 ((CW'(ctl.deg_val) == deg_r) && (ctl.sel < VIDX_W'(LANE)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r   <= '0;
      rank_r  <= '0;
      color_r <= '0;
    end else begin
      if (ctl.deg_we && mine) deg_r <= CW'(ctl.deg_val);
      if (ctl.rank_clr) rank_r <= '0;
      else if (ctl.rank_en && beats) rank_r <= rank_r + 1'b1;
      if (ctl.color_clr) color_r <= '0;
      else if (ctl.color_we && mine) color_r <= CW'(ctl.color_val);
    end
  end

  assign deg   = deg_r;
  assign rank  = rank_r;
  assign color = color_r;
endmodule
`default_nettype wire

// ----- rtl/gdc_merge.sv -----
// Merge stage: finds the active lane whose rank equals the requested position.
// Depends on gdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gdc_merge #(
  parameter int MAX_VERTICES = gdc_pkg::MAX_VERTICES_DEF
) (
  input  logic [$clog2(MAX_VERTICES)-1:0]   ranks [MAX_VERTICES],
  input  logic [$clog2(MAX_VERTICES+1)-1:0] n,
  input  logic [$clog2(MAX_VERTICES)-1:0]   target,
  output logic [$clog2(MAX_VERTICES)-1:0]   idx
);
  import gdc_pkg::*;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // ranks of active lanes form a permutation, so at most one lane hits
  always_comb begin
    idx = '0;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      if ((ranks[v] == target) && (CW'(v) < n)) idx = idx | VW'(v);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/greedy_degree_order_graph_coloring_top.sv -----
// Welsh-Powell graph colorer. Adjacency rows arrive one per beat on in_ch and
// are written into a row memory as each beat is taken. The beat with last_row
// set starts a pass: degrees are counted one row per cycle, vertex ranks are
// built by broadcasting one degree per cycle to all vertex lanes, then color
// classes are grown by walking the degree order with one row memory read and
// then one check per visited vertex. One result beat per vertex then leaves on
// out_ch in ascending vertex order. No row is taken during a pass; the row
// memory read port sets the pace of the coloring walk. vertex_count is
// written through cfg_we/cfg_wdata; the user must write it only while idle,
// which the block itself does not enforce. Zero acts as one vertex and values
// above MAX_VERTICES saturate. Rows are kept across passes.
// Depends on gdc_pkg, gdc_in_if, gdc_lane, gdc_merge, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module greedy_degree_order_graph_coloring_top #(
  parameter int MAX_VERTICES = gdc_pkg::MAX_VERTICES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  gdc_in_if.sink     in_ch,
  gdc_out_if.source  out_ch
);
  import gdc_pkg::*;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  gdc_state_t state_r, state_nxt;
  logic [5:0]              vcount_r;
  logic [CW-1:0]           j_r, j_nxt, cnt_r, cnt_nxt;
  logic [VW-1:0]           s_r, s_nxt, u_r, u_nxt, rd_addr, hit_idx;
  logic [MAX_VERTICES-1:0] colored_r, colored_nxt, forbid_r, forbid_nxt;
  logic                    joined_r, joined_nxt, join_now;
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rd_data_r;
  logic [CW-1:0]           n, n_last;
  logic [MAX_VERTICES-1:0] cols;
  lane_ctl_t               ctl;
  logic [CW-1:0]           deg_of [MAX_VERTICES];
  logic [VW-1:0]           rank_of [MAX_VERTICES];
  logic [CW-1:0]           color_of [MAX_VERTICES];
  logic                    in_fire, out_fire;

  // Active vertex count: zero means one, large values clamp to the build size
  always_comb begin
    if (vcount_r == '0) n = CW'(1);
    else if (7'(vcount_r) > 7'(MAX_VERTICES)) n = CW'(MAX_VERTICES);
    else n = CW'(vcount_r);
    n_last = n - 1'b1;
    for (int i = 0; i < MAX_VERTICES; i++) cols[i] = (CW'(i) < n);
  end

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 6'd32;
    else if (cfg_we) vcount_r <= cfg_wdata;
  end

  // Row memory: one write port for loading, one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && (7'(in_ch.row_index) < 7'(MAX_VERTICES)))
      adj_mem[VW'(in_ch.row_index)] <= MAX_VERTICES'(in_ch.adjacency_row);
    rd_data_r <= adj_mem[rd_addr];
  end

  // Vertex lanes work side by side; the merge stage picks the vertex at a rank
  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_lane
    gdc_lane #(.MAX_VERTICES(MAX_VERTICES), .LANE(g)) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .deg  (deg_of[g]),
      .rank (rank_of[g]),
      .color(color_of[g])
    );
  end

  gdc_merge #(.MAX_VERTICES(MAX_VERTICES)) u_merge (
    .ranks (rank_of),
    .n     (n),
    .target(s_r),
    .idx   (hit_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      j_r       <= '0;
      cnt_r     <= '0;
      s_r       <= '0;
      u_r       <= '0;
      colored_r <= '0;
      forbid_r  <= '0;
      joined_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      j_r       <= j_nxt;
      cnt_r     <= cnt_nxt;
      s_r       <= s_nxt;
      u_r       <= u_nxt;
      colored_r <= colored_nxt;
      forbid_r  <= forbid_nxt;
      joined_r  <= joined_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    j_nxt       = j_r;
    cnt_nxt     = cnt_r;
    s_nxt       = s_r;
    u_nxt       = u_r;
    colored_nxt = colored_r;
    forbid_nxt  = forbid_r;
    joined_nxt  = joined_r;
    rd_addr     = '0;
    ctl         = '0;
    join_now    = 1'b0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_fire && in_ch.last_row) begin
          ctl.rank_clr = 1'b1;
          j_nxt        = '0;
          state_nxt    = ST_DEG;
        end
      end
      ST_DEG: begin
        // read row j, count the row read last cycle
        if (j_r < n) rd_addr = j_r[VW-1:0];
        if (j_r != '0) begin
          ctl.deg_we  = 1'b1;
          ctl.sel     = VIDX_W'(j_r - 1'b1);
          ctl.deg_val = (VIDX_W+1)'($countones(rd_data_r & cols));
        end
        if (j_r == n) begin
          j_nxt     = '0;
          state_nxt = ST_RANK;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_RANK: begin
        ctl.rank_en = 1'b1;
        ctl.sel     = VIDX_W'(j_r);
        ctl.deg_val = (VIDX_W+1)'(deg_of[j_r[VW-1:0]]);
        j_nxt       = j_r + 1'b1;
        if (j_r == n_last) begin
          ctl.color_clr = 1'b1;
          colored_nxt   = '0;
          forbid_nxt    = '0;
          joined_nxt    = 1'b0;
          cnt_nxt       = '0;
          s_nxt         = '0;
          state_nxt     = ST_CLASS_RD;
        end
      end
      ST_CLASS_RD: begin
        rd_addr   = hit_idx;
        u_nxt     = hit_idx;
        state_nxt = ST_CLASS_CHK;
      end
      ST_CLASS_CHK: begin
        join_now = !colored_r[u_r] && !forbid_r[u_r];
        if (join_now) begin
          colored_nxt[u_r] = 1'b1;
          forbid_nxt       = forbid_r | rd_data_r;
          ctl.color_we     = 1'b1;
          ctl.sel          = VIDX_W'(u_r);
          ctl.color_val    = (VIDX_W+1)'(cnt_r + 1'b1);
        end
        if (CW'(s_r) == n_last) begin
          // class closed; open the next one or finish
          cnt_nxt = cnt_r + CW'(joined_r || join_now);
          if ((colored_nxt & cols) == cols) begin
            j_nxt     = '0;
            state_nxt = ST_EMIT;
          end else begin
            s_nxt      = '0;
            forbid_nxt = '0;
            joined_nxt = 1'b0;
            state_nxt  = ST_CLASS_RD;
          end
        end else begin
          s_nxt      = s_r + 1'b1;
          joined_nxt = joined_r || join_now;
          state_nxt  = ST_CLASS_RD;
        end
      end
      ST_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          if (j_r == n_last) state_nxt = ST_LOAD;
          else j_nxt = j_r + 1'b1;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Result beat: hold the payload until taken
  assign out_ch.vertex      = 5'(j_r);
  assign out_ch.color       = 6'(color_of[j_r[VW-1:0]]);
  assign out_ch.color_count = 6'(cnt_r);
  assign out_ch.last_result = (j_r == n_last);

  `ASSERT_NEVER(a_no_overlap, in_ch.ready && out_ch.valid)
  `ASSERT_NEXT(a_back_to_load, out_fire && out_ch.last_result, in_ch.ready)
  `ASSERT_IMPLY(a_all_colored, state_r == ST_EMIT, (colored_r & cols) == cols)
  `ASSERT_IMPLY(a_visit_active, state_r == ST_CLASS_CHK, CW'(u_r) < n)
endmodule
`default_nettype wire
